### hw/rtl/psa_pkg.sv
package psa_pkg;

   localparam int unsigned TIME_W = 48;

   typedef logic [TIME_W-1:0] time_type;

   typedef enum logic [2:0] {
      FUNC_RESET    = 3'd0,
      FUNC_START    = 3'd1,
      FUNC_STOP     = 3'd2,
      FUNC_PAUSE    = 3'd3,
      FUNC_CONTINUE = 3'd4,
      FUNC_TICK     = 3'd5
   } func_type;

   typedef struct packed {
      time_type stop_active;
      time_type elapsed;
      time_type active_time;
      time_type paused_time;
      logic     is_running;
      logic     is_paused;
   } timer_result_type;

   typedef struct packed {
      logic     clear;
      logic     record;
      time_type sample;
   } ring_ctrl_type;

endpackage

### hw/rtl/psa_timer.sv
module psa_timer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       process,
   input  logic [2:0]                 func,
   input  psa_pkg::time_type          time_now,
   input  psa_pkg::time_type          prev_tick,
   input  psa_pkg::time_type          delta,
   input  logic                       pause_enable,
   output psa_pkg::timer_result_type  result,
   output psa_pkg::ring_ctrl_type     ring_ctrl
);

   logic              running_ff, running_in;
   logic              paused_ff, paused_in;
   psa_pkg::time_type start_ff, start_in;
   psa_pkg::time_type pause_ff, pause_in;
   psa_pkg::time_type cont_ff, cont_in;
   psa_pkg::time_type since_ff, since_in;
   psa_pkg::time_type active_ff, active_in;
   psa_pkg::time_type paused_acc_ff, paused_acc_in;
   psa_pkg::time_type stop_active;
   logic              clear;
   logic              record;

   always_comb begin
      running_in    = running_ff;
      paused_in     = paused_ff;
      start_in      = start_ff;
      pause_in      = pause_ff;
      cont_in       = cont_ff;
      since_in      = since_ff;
      active_in     = active_ff;
      paused_acc_in = paused_acc_ff;
      stop_active   = '0;
      clear         = 1'b0;
      record        = 1'b0;
      unique case (func)
         psa_pkg::FUNC_RESET: begin
            clear      = 1'b1;
            running_in = 1'b0;
            paused_in  = 1'b0;
            start_in   = '0;
            pause_in   = '0;
            cont_in    = '0;
         end
         psa_pkg::FUNC_START: begin
            if (!running_ff) begin
               start_in      = time_now;
               since_in      = '0;
               active_in     = '0;
               paused_acc_in = '0;
               running_in    = 1'b1;
            end
         end
         psa_pkg::FUNC_STOP: begin
            if (running_ff) begin
               running_in  = 1'b0;
               since_in    = time_now - start_ff;
               active_in   = active_ff + (time_now - prev_tick);
               record      = 1'b1;
               stop_active = active_in;
            end
         end
         psa_pkg::FUNC_PAUSE: begin
            if (pause_enable && running_ff && !paused_ff) begin
               paused_in = 1'b1;
               pause_in  = time_now;
            end
         end
         psa_pkg::FUNC_CONTINUE: begin
            if (pause_enable && running_ff && paused_ff) begin
               cont_in   = time_now;
               paused_in = 1'b0;
            end
         end
         psa_pkg::FUNC_TICK: begin
            if (running_ff) begin
               since_in = time_now - start_ff;
               priority if (paused_ff) begin
                  if (prev_tick < pause_ff) begin
                     active_in     = active_ff + (pause_ff - prev_tick);
                     paused_acc_in = paused_acc_ff + (time_now - pause_ff);
                  end else begin
                     paused_acc_in = paused_acc_ff + delta;
                  end
               end else if (prev_tick < start_ff) begin
                  active_in = active_ff + (time_now - start_ff);
               end else if (cont_ff != '0 && prev_tick < cont_ff) begin
                  paused_acc_in = paused_acc_ff + (cont_ff - prev_tick);
                  active_in     = active_ff + (time_now - cont_ff);
                  pause_in      = '0;
                  cont_in       = '0;
               end else begin
                  active_in = active_ff + delta;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= 1'b0;
         paused_ff     <= 1'b0;
         start_ff      <= '0;
         pause_ff      <= '0;
         cont_ff       <= '0;
         since_ff      <= '0;
         active_ff     <= '0;
         paused_acc_ff <= '0;
      end else if (process) begin
         running_ff    <= running_in;
         paused_ff     <= paused_in;
         start_ff      <= start_in;
         pause_ff      <= pause_in;
         cont_ff       <= cont_in;
         since_ff      <= since_in;
         active_ff     <= active_in;
         paused_acc_ff <= paused_acc_in;
      end
   end

   assign result.stop_active = stop_active;
   assign result.elapsed     = since_in;
   assign result.active_time = active_in;
   assign result.paused_time = paused_acc_in;
   assign result.is_running  = running_in;
   assign result.is_paused   = paused_in;

   assign ring_ctrl.clear  = process && clear;
   assign ring_ctrl.record = process && record;
   assign ring_ctrl.sample = since_in;

endmodule

### hw/rtl/psa_ring.sv
module psa_ring #(
   parameter int unsigned SAMPLES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  psa_pkg::ring_ctrl_type ring_ctrl,
   output psa_pkg::time_type      average,
   output psa_pkg::time_type      last_sample
);

   localparam int unsigned IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int unsigned SHIFT = $clog2(SAMPLES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES - 1);

   psa_pkg::time_type mem [SAMPLES];
   logic [SAMPLES-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]   index_ff, index_in;
   psa_pkg::time_type  avg_ff, avg_in;
   psa_pkg::time_type  last_ff, last_in;
   psa_pkg::time_type  rd_ff;
   psa_pkg::time_type  old_sample;

   // The entry at the write index is fetched into a register ahead of time so that a stop can
   // take the retiring sample out of the average without a combinational read.
   assign old_sample = valid_ff[index_ff] ? rd_ff : '0;

   always_comb begin
      valid_in = valid_ff;
      index_in = index_ff;
      avg_in   = avg_ff;
      last_in  = last_ff;
      priority if (ring_ctrl.clear) begin
         valid_in = '0;
         index_in = '0;
         avg_in   = '0;
         last_in  = '0;
      end else if (ring_ctrl.record) begin
         valid_in[index_ff] = 1'b1;
         avg_in   = avg_ff - (old_sample >> SHIFT) + (ring_ctrl.sample >> SHIFT);
         last_in  = ring_ctrl.sample;
         index_in = (index_ff == LAST_IDX) ? '0 : index_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         index_ff <= '0;
         avg_ff   <= '0;
         last_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         index_ff <= index_in;
         avg_ff   <= avg_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_ctrl.record) begin
         mem[index_ff] <= ring_ctrl.sample;
      end
      if (ring_ctrl.record && index_in == index_ff) begin
         rd_ff <= ring_ctrl.sample;
      end else begin
         rd_ff <= mem[index_in];
      end
   end

   assign average     = avg_in;
   assign last_sample = last_in;

endmodule

### hw/rtl/pausable_stopwatch_accumulator.sv
// An accepted transaction is captured in the input register, is processed by the timer
// and ring when it advances, and its response is then held in the response register.
// Throughput: one transaction per cycle unless the response side stalls; then the input
// and response registers hold up to two transactions before the input stalls.
// Reset: synchronous, active high; clears all timer state, the sample ring valid
// bits, index, average and last sample, and sets pause_enable to 1.
module pausable_stopwatch_accumulator #(
   parameter int unsigned SAMPLES = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_func,
   input  psa_pkg::time_type   req_time_now,
   input  psa_pkg::time_type   req_prev_tick,
   input  psa_pkg::time_type   req_delta,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output psa_pkg::time_type   rsp_stop_active,
   output psa_pkg::time_type   rsp_elapsed,
   output psa_pkg::time_type   rsp_active_time,
   output psa_pkg::time_type   rsp_paused_time,
   output psa_pkg::time_type   rsp_average,
   output psa_pkg::time_type   rsp_last_sample,
   output logic                rsp_is_running,
   output logic                rsp_is_paused,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_wdata
);

   logic                      in_valid_ff, in_valid_in;
   logic [2:0]                func_ff;
   psa_pkg::time_type         now_ff;
   psa_pkg::time_type         prev_ff;
   psa_pkg::time_type         delta_ff;
   logic                      pause_enable_ff;
   logic                      out_valid_ff, out_valid_in;
   logic                      advance;
   logic                      load;
   psa_pkg::timer_result_type timer_result;
   psa_pkg::timer_result_type result_ff;
   psa_pkg::ring_ctrl_type    ring_ctrl;
   psa_pkg::time_type         average;
   psa_pkg::time_type         last_sample;
   psa_pkg::time_type         average_ff;
   psa_pkg::time_type         last_sample_ff;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign load      = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in  = load ? 1'b1 : (in_valid_ff && !advance);
      out_valid_in = advance ? 1'b1 : (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         pause_enable_ff <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            pause_enable_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         func_ff  <= req_func;
         now_ff   <= req_time_now;
         prev_ff  <= req_prev_tick;
         delta_ff <= req_delta;
      end
      if (advance) begin
         result_ff      <= timer_result;
         average_ff     <= average;
         last_sample_ff <= last_sample;
      end
   end

   psa_timer u_timer (
      .clock        (clock),
      .reset        (reset),
      .process      (advance),
      .func         (func_ff),
      .time_now     (now_ff),
      .prev_tick    (prev_ff),
      .delta        (delta_ff),
      .pause_enable (pause_enable_ff),
      .result       (timer_result),
      .ring_ctrl    (ring_ctrl)
   );

   psa_ring #(
      .SAMPLES (SAMPLES)
   ) u_ring (
      .clock       (clock),
      .reset       (reset),
      .ring_ctrl   (ring_ctrl),
      .average     (average),
      .last_sample (last_sample)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_stop_active = result_ff.stop_active;
   assign rsp_elapsed     = result_ff.elapsed;
   assign rsp_active_time = result_ff.active_time;
   assign rsp_paused_time = result_ff.paused_time;
   assign rsp_average     = average_ff;
   assign rsp_last_sample = last_sample_ff;
   assign rsp_is_running  = result_ff.is_running;
   assign rsp_is_paused   = result_ff.is_paused;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with no transaction held");

   a_advance_shows_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed transaction produced no response");

   a_reset_event_clears: assert property (@(posedge clock) disable iff (reset)
      advance && func_ff == psa_pkg::FUNC_RESET |=>
         !rsp_is_running && !rsp_is_paused && rsp_average == '0 && rsp_last_sample == '0)
      else $error("reset transaction left status or samples set");

   a_stop_halts: assert property (@(posedge clock) disable iff (reset)
      advance && func_ff == psa_pkg::FUNC_STOP |=> !rsp_is_running)
      else $error("stop transaction left the stopwatch running");

   a_record_needs_stop: assert property (@(posedge clock) disable iff (reset)
      ring_ctrl.record |-> advance && func_ff == psa_pkg::FUNC_STOP)
      else $error("sample recorded outside a stop transaction");

endmodule
